>>> rtl/iafp_pkg.sv
// Package: constants and types shared by the angle frame parser modules.
package iafp_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W = 4;
    localparam int YAW_W = 17;
    localparam int WORD_W = 16;

    // Frame header bytes
    localparam logic [BYTE_W-1:0] HDR_FIRST = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h53;
    localparam logic [BYTE_W-1:0] SUM_INIT = HDR_FIRST + HDR_SECOND;

    // Payload byte positions
    localparam logic [CNT_W-1:0] PL_YAW_LO = 4'd4;
    localparam logic [CNT_W-1:0] PL_YAW_HI = 4'd5;
    localparam logic [CNT_W-1:0] PL_TRL_LO = 4'd6;
    localparam logic [CNT_W-1:0] PL_TRL_HI = 4'd7;
    localparam logic [CNT_W-1:0] PL_SUM = 4'd8;

    // Half turn in raw yaw codes
    localparam logic [WORD_W-1:0] HALF_TURN = 16'h8000;

    // Completed frame, handed from the parser to the yaw stage
    typedef struct packed {
        logic              done;
        logic              ok;
        logic [WORD_W-1:0] yaw_raw;
        logic [WORD_W-1:0] trailer;
    } t_frame;

endpackage

>>> rtl/iafp_if.sv
// Interfaces: received byte channel and frame result channel.
interface iafp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface iafp_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] yaw_code;
    logic [16:0] yaw_change;
    logic [15:0] trailer_word;
    logic        checksum_ok;

    modport source (output valid, output yaw_code, output yaw_change, output trailer_word,
                    output checksum_ok, input ready);
    modport sink (input valid, input yaw_code, input yaw_change, input trailer_word,
                  input checksum_ok, output ready);
endinterface

>>> rtl/iafp_frame_fsm.sv
// Frame parser: input byte register, header hunt, payload capture and running sum.
module iafp_frame_fsm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_byte_vld,
    input  logic [iafp_pkg::BYTE_W-1:0] i_byte,
    output logic                      o_byte_rdy,
    input  logic                      i_out_block,
    output iafp_pkg::t_frame          o_frm
);
    import iafp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_DATA
    } t_phase;

    t_phase             r_phase;
    logic [CNT_W-1:0]   r_cnt;
    logic [BYTE_W-1:0]  r_sum;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_byte_vld;
    logic [BYTE_W-1:0]  r_yaw_lo;
    logic [BYTE_W-1:0]  r_yaw_hi;
    logic [BYTE_W-1:0]  r_trl_lo;
    logic [BYTE_W-1:0]  r_trl_hi;

    logic               frm_end;
    logic               stall;
    logic               adv;

    // Hold the closing byte while the result register is occupied and not being taken
    assign frm_end = r_byte_vld && (r_phase == PH_DATA) && (r_cnt == PL_SUM);
    assign stall = frm_end && i_out_block;
    assign adv = r_byte_vld && !stall;
    assign o_byte_rdy = !r_byte_vld || !stall;

    assign o_frm.done = frm_end && !stall;
    assign o_frm.ok = (r_sum == r_byte);
    assign o_frm.yaw_raw = {r_yaw_hi, r_yaw_lo};
    assign o_frm.trailer = {r_trl_hi, r_trl_lo};

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_vld <= 1'b0;
        end else if (o_byte_rdy) begin
            r_byte_vld <= i_byte_vld;
            r_byte <= i_byte;
        end
    end

    // Hunt for the header, then count and sum the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_cnt <= '0;
            r_sum <= SUM_INIT;
        end else if (adv) begin
            case (r_phase)
                PH_HUNT2: begin
                    r_phase <= (r_byte == HDR_SECOND) ? PH_DATA : PH_HUNT1;
                    r_cnt <= '0;
                    r_sum <= SUM_INIT;
                end
                PH_DATA: begin
                    r_sum <= r_sum + r_byte;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == PL_YAW_LO) r_yaw_lo <= r_byte;
                    if (r_cnt == PL_YAW_HI) r_yaw_hi <= r_byte;
                    if (r_cnt == PL_TRL_LO) r_trl_lo <= r_byte;
                    if (r_cnt == PL_TRL_HI) r_trl_hi <= r_byte;
                    if (r_cnt == PL_SUM) begin
                        r_phase <= PH_HUNT1;
                    end
                end
                default: begin
                    r_phase <= (r_byte == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

endmodule

>>> rtl/iafp_yaw_calc.sv
// Yaw stage: yaw decode, change against last good yaw, result register.
module iafp_yaw_calc (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iafp_pkg::t_frame          i_frm,
    output logic                      o_block,
    output logic                      o_vld,
    input  logic                      i_rdy,
    output logic [iafp_pkg::YAW_W-1:0]  o_yaw_code,
    output logic [iafp_pkg::YAW_W-1:0]  o_yaw_change,
    output logic [iafp_pkg::WORD_W-1:0] o_trailer,
    output logic                      o_ok
);
    import iafp_pkg::*;

    logic               r_vld;
    logic [YAW_W-1:0]   r_prev_yaw;
    logic [YAW_W-1:0]   r_yaw_code;
    logic [YAW_W-1:0]   r_yaw_change;
    logic [WORD_W-1:0]  r_trailer;
    logic               r_ok;

    logic [YAW_W-1:0]   yaw_code;
    logic [YAW_W-1:0]   yaw_change;

    // Raw words above a half turn wrap to negative
    assign yaw_code = (i_frm.yaw_raw > HALF_TURN) ? {1'b1, i_frm.yaw_raw}
                                                  : {1'b0, i_frm.yaw_raw};
    assign yaw_change = yaw_code - r_prev_yaw;

    assign o_block = r_vld && !i_rdy;

    // Result register; zero the fields of a failed frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_prev_yaw <= '0;
        end else if (i_frm.done) begin
            r_vld <= 1'b1;
            r_ok <= i_frm.ok;
            r_yaw_code <= i_frm.ok ? yaw_code : '0;
            r_yaw_change <= i_frm.ok ? yaw_change : '0;
            r_trailer <= i_frm.ok ? i_frm.trailer : '0;
            if (i_frm.ok) r_prev_yaw <= yaw_code;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    assign o_vld = r_vld;
    assign o_yaw_code = r_yaw_code;
    assign o_yaw_change = r_yaw_change;
    assign o_trailer = r_trailer;
    assign o_ok = r_ok;

endmodule

>>> rtl/imu_angle_frame_parser.sv
// Top level: angle frame parser for the inertial sensor's serial byte stream.
//
// i_in carries received serial bytes, one per transfer. The parser hunts for
// the header 0x55 0x53, takes nine payload bytes and checks the 8-bit sum of
// the header and the first eight payload bytes against the ninth.
// o_out carries one result per completed frame: yaw code, change since the
// last good yaw, the trailing word and the checksum flag. Failed frames give
// zero fields and leave the last good yaw alone.
// Throughput is one byte per cycle while no closing byte is held. Each byte
// passes through the input register; the result of a frame is registered in
// the result register when its closing byte leaves the input register.
// While a result waits on o_out, bytes keep being taken; only a frame's
// closing byte is held in the input register until the result register
// frees, and i_in.ready then drops.
// Reset (synchronous, active low) returns to the header hunt, clears the
// last good yaw to zero and empties both registers.
module imu_angle_frame_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iafp_byte_if.sink     i_in,
    iafp_result_if.source o_out
);
    import iafp_pkg::*;

    t_frame frm;
    logic   out_block;

    iafp_frame_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (i_in.valid),
        .i_byte     (i_in.rx_byte),
        .o_byte_rdy (i_in.ready),
        .i_out_block(out_block),
        .o_frm      (frm)
    );

    iafp_yaw_calc u_yaw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm       (frm),
        .o_block     (out_block),
        .o_vld       (o_out.valid),
        .i_rdy       (o_out.ready),
        .o_yaw_code  (o_out.yaw_code),
        .o_yaw_change(o_out.yaw_change),
        .o_trailer   (o_out.trailer_word),
        .o_ok        (o_out.checksum_ok)
    );

endmodule

>>> rtl/iafp_checker.sv
// Checker: port-level assertions for the angle frame parser, bound to the top level.
module iafp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_yaw_code,
    input logic [16:0] i_yaw_change,
    input logic [15:0] i_trailer_word,
    input logic        i_checksum_ok
);

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_yaw_code)
            && $stable(i_yaw_change) && $stable(i_trailer_word) && $stable(i_checksum_ok))
        else $error("stalled result changed");

    // A failed frame carries zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_checksum_ok |-> i_yaw_code == 17'd0 && i_yaw_change == 17'd0
            && i_trailer_word == 16'd0)
        else $error("failed frame with nonzero fields");

    // Yaw code stays within -32767 .. 32768
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $signed(i_yaw_code) >= -17'sd32767
            && $signed(i_yaw_code) <= 17'sd32768)
        else $error("yaw code out of range");

endmodule

bind imu_angle_frame_parser iafp_checker u_iafp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_yaw_code    (o_out.yaw_code),
    .i_yaw_change  (o_out.yaw_change),
    .i_trailer_word(o_out.trailer_word),
    .i_checksum_ok (o_out.checksum_ok)
);

>>> sim/tb.sv
// Testbench for imu_angle_frame_parser: byte stream stimulus with a frame predictor and result checks.
`timescale 1ns / 100ps

module tb;
    import iafp_pkg::*;

    localparam int PAYLOAD_BYTES   = 9;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        IN_PAYLOAD
    } t_hunt;

    typedef struct packed {
        logic [16:0] yaw_code;
        logic [16:0] yaw_change;
        logic [15:0] trailer_word;
        logic        checksum_ok;
    } t_angle_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    iafp_byte_if   in_if ();
    iafp_result_if out_if ();

    imu_angle_frame_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Frame tracker state
    t_hunt         hunt = SEEK_FIRST;
    int            pl_count = 0;
    logic [7:0]    pl_store [PAYLOAD_BYTES];
    logic [16:0]   last_good_yaw = '0;
    t_angle_result angle_q [$];

    // Traffic shaping
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Bookkeeping
    int bytes_sent = 0;
    int results_checked = 0;
    int good_results = 0;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    // Advance the frame tracker by one accepted byte; queue the frame result when one closes
    function automatic void track_byte(logic [7:0] b);
        t_angle_result r;
        logic [7:0]    sum;
        logic [15:0]   raw;
        int            k;
        case (hunt)
            SEEK_SECOND: begin
                hunt = (b == HDR_SECOND) ? IN_PAYLOAD : SEEK_FIRST;
                pl_count = 0;
            end
            IN_PAYLOAD: begin
                pl_store[pl_count % PAYLOAD_BYTES] = b;
                pl_count = (pl_count % PAYLOAD_BYTES) + 1;
                if (pl_count == PAYLOAD_BYTES) begin
                    hunt = SEEK_FIRST;
                    r = '0;
                    sum = SUM_INIT;
                    for (k = 0; k < PAYLOAD_BYTES - 1; k++)
                        sum = sum + pl_store[k];
                    if (sum == pl_store[PL_SUM]) begin
                        raw = {pl_store[PL_YAW_HI], pl_store[PL_YAW_LO]};
                        // Codes past a half turn wrap to the negative side
                        r.yaw_code = (raw > HALF_TURN) ? {1'b1, raw} : {1'b0, raw};
                        r.yaw_change = r.yaw_code - last_good_yaw;
                        r.trailer_word = {pl_store[PL_TRL_HI], pl_store[PL_TRL_LO]};
                        r.checksum_ok = 1'b1;
                        last_good_yaw = r.yaw_code;
                    end
                    angle_q.push_back(r);
                end
            end
            default: begin
                hunt = (b == HDR_FIRST) ? SEEK_SECOND : SEEK_FIRST;
            end
        endcase
    endfunction

    // Compare one delivered result against the oldest expectation
    function automatic void check_result(t_angle_result got);
        t_angle_result exp_r;
        bit            bad;
        results_checked++;
        if (angle_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("[%0t] unexpected result: yaw %0d change %0d trailer %h ok %b",
                         $realtime, $signed(got.yaw_code), $signed(got.yaw_change),
                         got.trailer_word, got.checksum_ok);
        end else begin
            exp_r = angle_q.pop_front();
            bad = 1'b0;
            if (got.yaw_code !== exp_r.yaw_code) bad = 1'b1;
            if (got.yaw_change !== exp_r.yaw_change) bad = 1'b1;
            if (got.trailer_word !== exp_r.trailer_word) bad = 1'b1;
            if (got.checksum_ok !== exp_r.checksum_ok) bad = 1'b1;
            if (exp_r.checksum_ok) good_results++;
            if (bad) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("[%0t] result %0d mismatch: expected yaw %0d change %0d trailer %h ok %b, got yaw %0d change %0d trailer %h ok %b",
                             $realtime, results_checked,
                             $signed(exp_r.yaw_code), $signed(exp_r.yaw_change),
                             exp_r.trailer_word, exp_r.checksum_ok,
                             $signed(got.yaw_code), $signed(got.yaw_change),
                             got.trailer_word, got.checksum_ok);
            end
        end
    endfunction

    // Sample both channels at the rising edge: check results first, then track bytes
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_if.valid && out_if.ready)
                check_result({out_if.yaw_code, out_if.yaw_change, out_if.trailer_word,
                              out_if.checksum_ok});
            if (in_if.valid && in_if.ready)
                track_byte(in_if.rx_byte);
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout: no transfer for %0d cycles, %0d results pending",
                         $realtime, quiet_cycles, angle_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Drive result ready: random stalls, or a long hold-off on request
    always @(negedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one byte, idling at random first; return at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.rx_byte <= b;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Send header and nine payload bytes; corrupt the sum byte when asked
    task automatic send_frame(input logic [15:0] yaw_raw, input logic [15:0] trailer,
                              input bit corrupt);
        logic [7:0] pl [PAYLOAD_BYTES];
        logic [7:0] sum;
        int         k;
        for (k = 0; k < PAYLOAD_BYTES; k++)
            pl[k] = 8'($urandom_range(255));
        pl[PL_YAW_LO] = yaw_raw[7:0];
        pl[PL_YAW_HI] = yaw_raw[15:8];
        pl[PL_TRL_LO] = trailer[7:0];
        pl[PL_TRL_HI] = trailer[15:8];
        sum = SUM_INIT;
        for (k = 0; k < PAYLOAD_BYTES - 1; k++)
            sum = sum + pl[k];
        pl[PL_SUM] = corrupt ? (sum ^ 8'($urandom_range(255, 1))) : sum;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (k = 0; k < PAYLOAD_BYTES; k++)
            send_byte(pl[k]);
    endtask

    // Favor the wrap points of the yaw code
    function automatic logic [15:0] pick_yaw();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h8001;
            3: return 16'hFFFF;
            4: return 16'h7FFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_trailer();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Drop valid and hold off until every queued result has been delivered
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (angle_q.size() != 0) @(negedge clk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Header hunt corner cases, then good and failed frames at the yaw extremes
    task automatic test_directed_frames();
        set_idling(0, 0);
        // A repeated first header byte must not restart the header
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_frame(16'h8000, 16'hFFFF, 1'b0);
        // A failed frame must leave the last good yaw alone
        send_frame(16'h7FFF, 16'h1234, 1'b1);
        send_frame(16'h8001, 16'h0000, 1'b0);
        wait_for_results();
    endtask

    // Mostly well-formed frames, plus failed sums, broken headers and line noise
    task automatic test_random_traffic(input int n_bytes);
        int         start;
        int         n;
        int         k;
        logic [7:0] b;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            n = $urandom_range(99);
            if (n < 70) begin
                send_frame(pick_yaw(), pick_trailer(), 1'b0);
            end else if (n < 82) begin
                send_frame(pick_yaw(), pick_trailer(), 1'b1);
            end else if (n < 90) begin
                b = ($urandom_range(3) == 0) ? HDR_FIRST : 8'($urandom_range(255));
                if (b == HDR_SECOND) b = ~b;
                send_byte(HDR_FIRST);
                send_byte(b);
            end else begin
                for (k = 0; k <= $urandom_range(2); k++)
                    send_byte(8'($urandom_range(255)));
            end
        end
        wait_for_results();
    endtask

    // Hold off the result side while frames keep coming, so the input stalls
    task automatic test_result_backpressure();
        int k;
        set_idling(0, 0);
        hold_req++;
        for (k = 0; k < 4; k++)
            send_frame(pick_yaw(), pick_trailer(), 1'b0);
        wait_for_results();
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.rx_byte = '0;
        out_if.ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_frames();
        set_idling(0, 0);
        test_random_traffic(350);
        set_idling(55, 0);
        test_random_traffic(350);
        set_idling(0, 55);
        test_random_traffic(350);
        set_idling(8, 8);
        test_random_traffic(350);
        test_result_backpressure();

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Sent %0d bytes across idle, sender-gap, receiver-stall and hold-off phases.",
                 bytes_sent);
        $display("Checked %0d frame results (%0d with a good sum), %0d mismatches.",
                 results_checked, good_results, mismatch_cnt);
        if (mismatch_cnt == 0 && angle_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/iafp_pkg.sv
rtl/iafp_if.sv
rtl/iafp_frame_fsm.sv
rtl/iafp_yaw_calc.sv
rtl/imu_angle_frame_parser.sv
rtl/iafp_checker.sv
sim/tb.sv
